### rtl/handle_id_registry_defines.svh
// Assertion macros shared by the handle/ID registry checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef HANDLE_ID_REGISTRY_DEFINES_SVH
`define HANDLE_ID_REGISTRY_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define HIR_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define HIR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hir_pkg.sv
// Shared types and constants for the handle/ID registry.
// No dependencies; used by every module of the block except hir_ram.
package hir_pkg;

	// Default sizing
	localparam int DEPTH_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 32;

	// Port field layout
	localparam int HANDLE_W   = 32;
	localparam int ID_IN_W    = 16;
	localparam int ID_OUT_W   = 7;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 40;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_NEW      = 3'd1,
		ST_NULL     = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_code_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture request, restart scan
		logic issue;   // read next slot
		logic commit;  // write back, update high mark, load result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;     // nothing to read for this request
		logic last;      // current read is the final one
		logic out_free;  // result register can take a value
	} dp_status_t;

endpackage

### rtl/hir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/hir_ctrl.sv
// Sequencing state machine for the handle/ID registry.
// Depends on hir_pkg for the command and status structs.
module hir_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output hir_pkg::cmd_t           cmd,
	input  hir_pkg::dp_status_t     st
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.empty) begin
					state_d = S_DONE;
				end else begin
					cmd.issue = 1'b1;
					if (st.last) begin
						state_d = S_DRAIN;
					end
				end
			end
			// last read data is compared here
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

### rtl/hir_datapath.sv
// Request registers, slot scan, high mark, write-back and result register.
// Depends on hir_pkg and instantiates hir_ram for the slot store.
module hir_datapath #(
	parameter int DEPTH       = hir_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = hir_pkg::HANDLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [hir_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [hir_pkg::MODE_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hir_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [hir_pkg::STATUS_W-1:0]      m_tuser,
	input  hir_pkg::cmd_t                     cmd,
	output hir_pkg::dp_status_t               st
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDW = $clog2(DEPTH + 1);
	localparam int HW  = hir_pkg::HANDLE_W;
	localparam int IW  = hir_pkg::ID_IN_W;
	localparam int OW  = hir_pkg::ID_OUT_W;

	// Request
	logic [hir_pkg::MODE_W-1:0] mode_q;
	logic [HANDLE_BITS-1:0]     h_q;
	logic [IW-1:0]              idv_q;

	// Table state and scan
	logic [IDW-1:0]         hm_q;
	logic [AW-1:0]          idx_q;
	logic                   rv_s1;
	logic [AW-1:0]          idx_s1;
	logic                   match_q;
	logic [IDW-1:0]         match_id_q;
	logic                   vac_q;
	logic [IDW-1:0]         vac_id_q;
	logic [HANDLE_BITS-1:0] look_q;

	// Result register
	logic                       out_valid_q;
	logic [OW-1:0]              out_id_q;
	logic [HW-1:0]              out_handle_q;
	hir_pkg::status_code_t      out_status_q;

	// Slot store ports
	logic [AW-1:0]          rd_addr;
	logic [HANDLE_BITS-1:0] rd_data;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [HANDLE_BITS-1:0] wr_data;

	// Commit decisions
	logic                  in_range;
	logic                  hm_inc;
	logic [IDW-1:0]        res_id;
	logic [HANDLE_BITS-1:0] res_handle;
	hir_pkg::status_code_t res_status;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser;
			h_q    <= HANDLE_BITS'(s_tdata[HW-1:0]);
			idv_q  <= s_tdata[HW+IW-1:HW];
		end
	end

	assign in_range = (idv_q != '0) && (idv_q <= IW'(hm_q));

	// Scan status
	always_comb begin
		st.empty = 1'b0;
		case (mode_q)
			hir_pkg::MODE_GET:    st.empty = (h_q == '0) || (hm_q == '0);
			hir_pkg::MODE_LOOKUP: st.empty = !in_range;
			hir_pkg::MODE_REMOVE: st.empty = (hm_q == '0);
			default:              st.empty = 1'b1;
		endcase
	end

	assign st.last     = (mode_q == hir_pkg::MODE_LOOKUP) ||
	                     ((IDW'(idx_q) + IDW'(1)) == hm_q);
	assign st.out_free = !out_valid_q || m_tready;

	assign rd_addr = (mode_q == hir_pkg::MODE_LOOKUP) ? AW'(idv_q - IW'(1)) : idx_q;

	// Scan pipeline: read issued one cycle, compared the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rv_s1   <= 1'b0;
			match_q <= 1'b0;
			vac_q   <= 1'b0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			rv_s1   <= 1'b0;
			match_q <= 1'b0;
			vac_q   <= 1'b0;
		end else begin
			rv_s1 <= cmd.issue;
			if (cmd.issue) begin
				idx_q <= idx_q + AW'(1);
			end
			if (rv_s1 && !match_q && (rd_data == h_q)) begin
				match_q <= 1'b1;
			end
			if (rv_s1 && !vac_q && (rd_data == '0)) begin
				vac_q <= 1'b1;
			end
		end
	end

	// Scan payload
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1 <= idx_q;
		end
		if (rv_s1) begin
			look_q <= rd_data;
			if (!match_q) begin
				match_id_q <= IDW'(idx_s1) + IDW'(1);
			end
			if (!vac_q) begin
				vac_id_q <= IDW'(idx_s1) + IDW'(1);
			end
		end
	end

	// Result and write-back selection
	always_comb begin
		res_id     = '0;
		res_handle = '0;
		res_status = hir_pkg::ST_NOTFOUND;
		wr_en      = 1'b0;
		wr_addr    = AW'(vac_id_q - IDW'(1));
		wr_data    = h_q;
		hm_inc     = 1'b0;
		case (mode_q)
			hir_pkg::MODE_GET: begin
				if (h_q == '0) begin
					res_status = hir_pkg::ST_NULL;
				end else if (match_q) begin
					res_id     = match_id_q;
					res_status = hir_pkg::ST_FOUND;
				end else if (vac_q) begin
					wr_en      = 1'b1;
					res_id     = vac_id_q;
					res_status = hir_pkg::ST_NEW;
				end else if (hm_q < IDW'(DEPTH)) begin
					wr_en      = 1'b1;
					wr_addr    = AW'(hm_q);
					hm_inc     = 1'b1;
					res_id     = hm_q + IDW'(1);
					res_status = hir_pkg::ST_NEW;
				end else begin
					res_status = hir_pkg::ST_FULL;
				end
			end
			hir_pkg::MODE_LOOKUP: begin
				if (in_range) begin
					res_handle = look_q;
					res_status = (look_q != '0) ? hir_pkg::ST_FOUND : hir_pkg::ST_NOTFOUND;
				end
			end
			hir_pkg::MODE_REMOVE: begin
				if (match_q) begin
					wr_en      = 1'b1;
					wr_addr    = AW'(match_id_q - IDW'(1));
					wr_data    = '0;
					res_id     = match_id_q;
					res_status = hir_pkg::ST_FOUND;
				end
			end
			default: begin
				res_status = hir_pkg::ST_NOTFOUND;
			end
		endcase
	end

	// High mark and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && hm_inc) begin
				hm_q <= hm_q + IDW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_id_q     <= OW'(res_id);
			out_handle_q <= HW'(res_handle);
			out_status_q <= res_status;
		end
	end

	// Slot store
	hir_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.commit && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.issue),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(hir_pkg::M_TDATA_W - OW - HW){1'b0}}, out_handle_q, out_id_q};
	assign m_tuser  = out_status_q;

endmodule

### rtl/handle_id_registry.sv
// Top level of the handle/ID registry: controller plus datapath.
// Depends on hir_pkg, hir_ctrl, hir_datapath (and through it hir_ram).
//
//  channel   dir  tdata fields (lsb up)        tuser fields
//  s_*       in   handle[31:0], id[47:32]      mode[1:0]
//  m_*       out  id_out[6:0], handle_out[38:7] status[2:0]
//
// Get/register and remove scan the slots 1..high mark through the single
// read port of the slot RAM, one entry a cycle. An in-range look-up reads
// its one slot; a null get, an unused mode, an out-of-range look-up or an
// empty table read none. Reset clears the high mark, the scan index and
// flags, the result valid and the controller state only; slots above the
// high mark are never read, so no clearing pass is needed.
// A result left waiting in the output register stalls the next request at
// write-back, and so holds off the input until it is taken.
module handle_id_registry #(
	parameter int DEPTH       = hir_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = hir_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hir_pkg::S_TDATA_W-1:0] s_tdata,  // handle[31:0], id[47:32]
	input  logic [hir_pkg::MODE_W-1:0]    s_tuser,  // mode[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hir_pkg::M_TDATA_W-1:0] m_tdata,  // id_out[6:0], handle_out[38:7], zero pad
	output logic [hir_pkg::STATUS_W-1:0]  m_tuser   // status[2:0]
);

	hir_pkg::cmd_t       cmd;
	hir_pkg::dp_status_t st;

	hir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	hir_datapath #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

### rtl/hir_checker.sv
// Port-level checks for the handle/ID registry, bound to the top level.
// Depends on hir_pkg and handle_id_registry_defines.svh.
`include "handle_id_registry_defines.svh"

module hir_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hir_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [hir_pkg::STATUS_W-1:0]  m_tuser
);

	// no result while in reset
	`HIR_ASSERT_RST(a_rst_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

	// stalled result holds
	`HIR_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// one request at a time
	`HIR_ASSERT_CLK(a_one_req, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

	// a handle comes back only with a successful look-up
	`HIR_ASSERT_CLK(a_handle_found, m_tvalid && (m_tdata[38:7] != 32'd0) |-> m_tuser == hir_pkg::ST_FOUND, "handle with bad status")

endmodule

bind handle_id_registry hir_checker u_hir_checker (.*);
